// ===== src/klcg_pkg.sv =====
// shared types, constants and lookup functions for the keyed lcg text descrambler
// no dependencies; used by klcg_core and keyed_lcg_text_descrambler_unit
`default_nettype none

package klcg_pkg;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_SEED = 2'd1,
        PH_DATA = 2'd2,
        PH_PASS = 2'd3
    } t_phase;

    // results caused by one character: some header characters, then one final item
    typedef struct packed {
        logic [2:0] hdr_cnt;
        logic       fin_ok;
        logic [7:0] fin_char;
        logic       fin_valid;
        logic       fin_dec;
        logic       fin_last;
    } t_grp;

    localparam int          HDR_LEN  = 5;
    localparam logic [31:0] LCG_MUL  = 32'd16777213;
    localparam logic [31:0] LCG_ADD  = 32'd6423135;
    localparam logic [39:0] HDR_STR  = "*#**#";
    localparam logic [127:0] BOOK_STR = "6psUoSXW3rVZhI1z";
    // key string repeated to fill all 64 index values
    localparam logic [511:0] KEY_STR =
        "faieugrf;owtnpi4u5hutkerfbuoery4ug3faieugrf;owtnpi4u5hutkerfbuoe";

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] r;
        r = 8'd0;
        if (idx < 3'(HDR_LEN)) begin
            r = HDR_STR[8 * (HDR_LEN - 1 - int'(idx)) +: 8];
        end
        return r;
    endfunction

    // codebook position, 16 when the character is not in the book
    function automatic logic [4:0] book_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        for (int i = 15; i >= 0; i--) begin
            if (c == BOOK_STR[8 * (15 - i) +: 8]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] key_byte(input logic [5:0] idx);
        return KEY_STR[8 * (63 - int'(idx)) +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== src/klcg_core.sv =====
// descrambler state: header check, seed assembly, pair decode and lcg step
// depends on klcg_pkg; results of one character leave as a t_grp
`default_nettype none

module klcg_core #(
    parameter int KEY_LENGTH = 35
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic [7:0]     i_char,
    input  wire logic           i_last,
    output klcg_pkg::t_grp      o_grp
);
    import klcg_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_pos,    n_pos;
    logic [31:0] r_seed,   n_seed;
    logic [4:0]  r_held,   n_held;
    logic        r_half,   n_half;
    logic [5:0]  r_key,    n_key;

    logic [4:0]  dec;
    logic [35:0] nib_w;
    logic [8:0]  pair_w;
    logic [6:0]  key_inc;
    logic        hdr_hit;

    always_comb begin
        dec     = book_decode(i_char);
        nib_w   = {31'b0, dec} << {r_pos, 2'b00};
        pair_w  = {4'b0, r_held} | {dec, 4'b0};
        key_inc = {1'b0, r_key} + 7'd1;
        hdr_hit = (r_pos < 3'(HDR_LEN)) && (i_char == hdr_char(r_pos));

        n_phase = r_phase;
        n_pos   = r_pos;
        n_seed  = r_seed;
        n_held  = r_held;
        n_half  = r_half;
        n_key   = r_key;

        o_grp           = '0;
        o_grp.fin_last  = i_last;

        case (r_phase)
            PH_HDR: begin
                if (hdr_hit) begin
                    if (r_pos == 3'(HDR_LEN - 1)) begin
                        n_phase = PH_SEED;
                        n_pos   = 3'd0;
                        o_grp.fin_ok = i_last;
                    end else begin
                        n_pos = r_pos + 3'd1;
                        if (i_last) begin
                            o_grp.hdr_cnt   = r_pos;
                            o_grp.fin_ok    = 1'b1;
                            o_grp.fin_char  = i_char;
                            o_grp.fin_valid = 1'b1;
                        end
                    end
                end else begin
                    o_grp.hdr_cnt   = (r_pos > 3'(HDR_LEN)) ? 3'(HDR_LEN) : r_pos;
                    o_grp.fin_ok    = 1'b1;
                    o_grp.fin_char  = i_char;
                    o_grp.fin_valid = 1'b1;
                    n_phase = PH_PASS;
                    n_pos   = 3'd0;
                end
            end
            PH_SEED: begin
                n_seed = r_seed | nib_w[31:0];
                if (r_pos == 3'd7) begin
                    n_phase = PH_DATA;
                    n_pos   = 3'd0;
                end else begin
                    n_pos = r_pos + 3'd1;
                end
                o_grp.fin_ok = i_last;
            end
            PH_DATA: begin
                if (!r_half) begin
                    n_held = dec;
                    n_half = 1'b1;
                    o_grp.fin_ok = i_last;
                end else begin
                    o_grp.fin_ok    = 1'b1;
                    o_grp.fin_char  = pair_w[7:0] ^ r_seed[7:0] ^ key_byte(r_key);
                    o_grp.fin_valid = 1'b1;
                    o_grp.fin_dec   = 1'b1;
                    n_seed = r_seed * LCG_MUL + LCG_ADD;
                    n_key  = (key_inc >= 7'(KEY_LENGTH)) ? 6'd0 : key_inc[5:0];
                    n_half = 1'b0;
                end
            end
            PH_PASS: begin
                o_grp.fin_ok    = 1'b1;
                o_grp.fin_char  = i_char;
                o_grp.fin_valid = 1'b1;
            end
            default: begin
                n_phase = PH_HDR;
            end
        endcase

        // end of text: start over for the next one
        if (i_last) begin
            n_phase = PH_HDR;
            n_pos   = 3'd0;
            n_seed  = 32'd0;
            n_held  = 5'd0;
            n_half  = 1'b0;
            n_key   = 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_pos   <= 3'd0;
            r_seed  <= 32'd0;
            r_held  <= 5'd0;
            r_half  <= 1'b0;
            r_key   <= 6'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_seed  <= n_seed;
            r_held  <= n_held;
            r_half  <= n_half;
            r_key   <= n_key;
        end
    end

endmodule

`default_nettype wire

// ===== src/keyed_lcg_text_descrambler_unit.sv =====
// top level of the keyed lcg text descrambler: stream ports and result serializer
// depends on klcg_pkg and klcg_core
`default_nettype none

// Descrambles a text one character per request. A result appears on the master
// side in the cycle after its character is taken. A character yields at most one
// result except when the header check fails or the text ends inside the header;
// then the matched header characters and the current one come out, up to five,
// one per cycle while the master takes them, and the slave side waits until the
// last of them is taken. Otherwise one character is taken every cycle unless a
// result is held, set by the single result register, which accepts a new group
// in the cycle its final result leaves. Characters that cause no result (seed,
// first half of a pair) leave nothing in the result register. The end marker of
// a text with no trailing result comes out with tuser all zero and tlast set.
module keyed_lcg_text_descrambler_unit #(
    parameter int KEY_LENGTH = 35
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  wire logic       i_s_axis_tlast,   // last_in
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_char
    output logic [1:0]      o_m_axis_tuser,   // [0] out_valid, [1] out_decoded
    output logic            o_m_axis_tlast    // out_last
);
    import klcg_pkg::*;

    t_grp       core_grp;
    t_grp       r_grp;
    logic       r_grp_vld;
    logic [2:0] r_idx;
    logic       s_take;
    logic       m_take;
    logic       at_end;

    assign at_end          = (r_idx == r_grp.hdr_cnt);
    assign m_take          = r_grp_vld && i_m_axis_tready;
    assign o_s_axis_tready = !r_grp_vld || (m_take && at_end);
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;

    klcg_core #(
        .KEY_LENGTH (KEY_LENGTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_take),
        .i_char  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_grp   (core_grp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_vld <= 1'b0;
            r_idx     <= 3'd0;
        end else if (s_take) begin
            r_grp_vld <= core_grp.fin_ok;
            r_idx     <= 3'd0;
        end else if (m_take) begin
            if (at_end) begin
                r_grp_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_grp <= core_grp;
        end
    end

    // header characters first, then the item the character itself caused
    always_comb begin
        o_m_axis_tvalid = r_grp_vld;
        if (at_end) begin
            o_m_axis_tdata = r_grp.fin_char;
            o_m_axis_tuser = {r_grp.fin_dec, r_grp.fin_valid};
            o_m_axis_tlast = r_grp.fin_last;
        end else begin
            o_m_axis_tdata = hdr_char(r_idx);
            o_m_axis_tuser = 2'b01;
            o_m_axis_tlast = 1'b0;
        end
    end

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_vld |-> (r_idx <= r_grp.hdr_cnt))
        else $error("serializer index beyond its group");

    a_ready_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_axis_tready && r_grp_vld) |-> (i_m_axis_tready && at_end))
        else $error("new character taken while results still pending");

    a_decoded_is_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tuser[0])
        else $error("decoded result without a character");

    a_header_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp_vld && !at_end) |-> !o_m_axis_tlast)
        else $error("header replay marked as final");

endmodule

`default_nettype wire

// ===== test/keyed_lcg_text_descrambler_unit_tb.sv =====
// self-checking testbench for keyed_lcg_text_descrambler_unit: directed texts, then random ones
// predicts every result in-bench and compares field by field; depends on klcg_pkg and the rtl
module keyed_lcg_text_descrambler_unit_tb;
    import klcg_pkg::*;

    localparam int          KEY_LEN     = 35;
    localparam int          STALL_LIMIT = 4000;
    localparam logic [31:0] SEED_MUL    = 32'd16777213;
    localparam logic [31:0] SEED_INC    = 32'd6423135;
    localparam string       HDR_TXT     = "*#**#";
    localparam string       BOOK_TXT    = "6psUoSXW3rVZhI1z";
    localparam string       KEY_TXT     = "faieugrf;owtnpi4u5hutkerfbuoery4ug3";

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } t_char_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       vld;
        logic       dec;
        logic       lst;
    } t_text_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire [7:0]  m_tdata;
    wire [1:0]  m_tuser;
    wire        m_tlast;

    keyed_lcg_text_descrambler_unit #(
        .KEY_LENGTH(KEY_LEN)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    t_char_req   char_queue[$];
    t_text_out   text_results[$];
    t_char_req   next_req;
    int          err_count = 0;
    int          launched = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int          idle_cycles = 0;
    bit          steady = 1'b0;
    bit          drain_hold = 1'b0;

    // predictor state
    t_phase      ph = PH_HDR;
    logic [2:0]  hdr_pos = 3'd0;
    logic [31:0] lcg = 32'd0;
    logic [4:0]  low_nib = 5'd0;
    logic        have_low = 1'b0;
    int          key_pos = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // codebook index, 16 for characters outside the book
    function automatic logic [4:0] book_nibble(input logic [7:0] c);
        for (int i = 0; i < 16; i++) begin
            if (BOOK_TXT[i] == c) begin
                return 5'(i);
            end
        end
        return 5'd16;
    endfunction

    function automatic logic [7:0] book_char();
        return BOOK_TXT[$urandom_range(0, 15)];
    endfunction

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic add_char(input logic [7:0] c, input logic lst);
        t_char_req r;
        r.ch = c;
        r.lst = lst;
        char_queue = {char_queue, r};
    endtask

    task automatic expect_out(input logic [7:0] c, input logic v, input logic d, input logic l);
        t_text_out o;
        o.ch = c;
        o.vld = v;
        o.dec = d;
        o.lst = l;
        text_results = {text_results, o};
    endtask

    task automatic expect_header(input int cnt);
        for (int i = 0; i < cnt; i++) begin
            expect_out(HDR_TXT[i], 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic descramble_char(input logic [7:0] c, input logic lst);
        int          p;
        logic [4:0]  nib;
        logic [63:0] wide;
        logic [8:0]  pair;
        logic [7:0]  b;
        p = int'(hdr_pos);
        nib = book_nibble(c);
        case (ph)
            PH_HDR: begin
                if (p < 5 && c == HDR_TXT[p]) begin
                    if (p == 4) begin
                        ph = PH_SEED;
                        hdr_pos = 3'd0;
                        if (lst) begin
                            expect_out(8'd0, 1'b0, 1'b0, 1'b1);
                        end
                    end else begin
                        hdr_pos = 3'(p + 1);
                        if (lst) begin
                            expect_header(p);
                            expect_out(c, 1'b1, 1'b0, 1'b1);
                        end
                    end
                end else begin
                    expect_header(p);
                    expect_out(c, 1'b1, 1'b0, lst);
                    ph = PH_PASS;
                    hdr_pos = 3'd0;
                end
            end
            PH_SEED: begin
                // an out-of-book nibble in the top slot loses its high bit
                wide = 64'(nib) << (4 * p);
                lcg = lcg | wide[31:0];
                if (p >= 7) begin
                    ph = PH_DATA;
                    hdr_pos = 3'd0;
                end else begin
                    hdr_pos = 3'(p + 1);
                end
                if (lst) begin
                    expect_out(8'd0, 1'b0, 1'b0, 1'b1);
                end
            end
            PH_DATA: begin
                if (!have_low) begin
                    low_nib = nib;
                    have_low = 1'b1;
                    if (lst) begin
                        expect_out(8'd0, 1'b0, 1'b0, 1'b1);
                    end
                end else begin
                    pair = 9'(low_nib) | (9'(nib) << 4);
                    b = pair[7:0] ^ lcg[7:0] ^ KEY_TXT[key_pos % KEY_TXT.len()];
                    expect_out(b, 1'b1, 1'b1, lst);
                    lcg = lcg * SEED_MUL + SEED_INC;
                    key_pos = (key_pos + 1 >= KEY_LEN) ? 0 : key_pos + 1;
                    have_low = 1'b0;
                end
            end
            default: begin
                expect_out(c, 1'b1, 1'b0, lst);
            end
        endcase
        if (lst) begin
            ph = PH_HDR;
            hdr_pos = 3'd0;
            lcg = 32'd0;
            low_nib = 5'd0;
            have_low = 1'b0;
            key_pos = 0;
        end
    endtask

    // well-formed text: header, seed, pairs, maybe an odd trailing character
    task automatic add_text(input int pairs, input bit odd);
        int n;
        n = 13 + 2 * pairs + int'(odd);
        for (int i = 0; i < n; i++) begin
            if (i < 5) begin
                add_char(HDR_TXT[i], i == n - 1);
            end else if ($urandom_range(0, 9) == 0) begin
                add_char(any_char(), i == n - 1);
            end else begin
                add_char(book_char(), i == n - 1);
            end
        end
    endtask

    task automatic build_stimulus();
        int k;
        int len;
        int kind;
        bit first_long;
        // header cut short by the end of text
        add_char("*", 1'b0);
        add_char("#", 1'b0);
        add_char("*", 1'b1);
        // mismatch on the last header character, then pass-through
        add_char("*", 1'b0);
        add_char("#", 1'b0);
        add_char("*", 1'b0);
        add_char("*", 1'b0);
        add_char("Q", 1'b0);
        add_char("z", 1'b1);
        // full header, seed with book extremes and an out-of-book top nibble,
        // out-of-book low half of a pair, then a dropped odd character
        for (int i = 0; i < 5; i++) begin
            add_char(HDR_TXT[i], 1'b0);
        end
        add_char("6", 1'b0);
        add_char("z", 1'b0);
        add_char("z", 1'b0);
        add_char("6", 1'b0);
        add_char("S", 1'b0);
        add_char("3", 1'b0);
        add_char("h", 1'b0);
        add_char(8'h01, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char("z", 1'b0);
        add_char("p", 1'b1);
        // text ending right on the header
        for (int i = 0; i < 5; i++) begin
            add_char(HDR_TXT[i], i == 4);
        end

        first_long = 1'b1;
        k = char_queue.size();
        while (char_queue.size() - k < 260) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    add_char(any_char(), i == len - 1);
                end
            end else if (kind == 1) begin
                len = $urandom_range(0, 4);
                for (int i = 0; i < len; i++) begin
                    add_char(HDR_TXT[i], 1'b0);
                end
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    add_char(any_char(), i == len - 1);
                end
            end else if (kind == 2) begin
                len = $urandom_range(1, 13);
                for (int i = 0; i < len; i++) begin
                    add_char(i < 5 ? HDR_TXT[i] : book_char(), i == len - 1);
                end
            end else if (first_long || $urandom_range(0, 7) == 0) begin
                // long enough for the key index to wrap
                first_long = 1'b0;
                add_text($urandom_range(36, 42), $urandom_range(0, 3) == 0);
            end else begin
                add_text($urandom_range(0, 8), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                descramble_char(s_tdata, s_tlast);
                if ($urandom_range(0, 39) == 0) begin
                    steady = !steady;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (drain_hold) begin
                    if (text_results.size() == 0) begin
                        drain_hold = 1'b0;
                    end
                    s_tvalid <= 1'b0;
                end else if (char_queue.size() != 0) begin
                    next_req = char_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_req.ch;
                    s_tlast <= next_req.lst;
                    launched++;
                    tx_gap = idle_len();
                    if (launched == 90 || launched == 200) begin
                        drain_hold = 1'b1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_text_out want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (text_results.size() == 0) begin
                    $display("%0t: unexpected result char=%h user=%b last=%b", $time,
                             m_tdata, m_tuser, m_tlast);
                    err_count++;
                end else begin
                    want = text_results.pop_front();
                    if (m_tdata !== want.ch) begin
                        $display("%0t: out_char expected %h actual %h", $time, want.ch, m_tdata);
                        err_count++;
                    end
                    if (m_tuser[0] !== want.vld) begin
                        $display("%0t: out_valid expected %b actual %b", $time, want.vld,
                                 m_tuser[0]);
                        err_count++;
                    end
                    if (m_tuser[1] !== want.dec) begin
                        $display("%0t: out_decoded expected %b actual %b", $time, want.dec,
                                 m_tuser[1]);
                        err_count++;
                    end
                    if (m_tlast !== want.lst) begin
                        $display("%0t: out_last expected %b actual %b", $time, want.lst, m_tlast);
                        err_count++;
                    end
                end
            end
            if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap = idle_len();
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        build_stimulus();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (char_queue.size() != 0 || s_tvalid || text_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
